[hdl/ofdp_pkg.sv]
`default_nettype none

package ofdp_pkg;

  // Field codes
  localparam logic [4:0] F_NODE_INDEX  = 5'd0;
  localparam logic [4:0] F_NODE_TYPE   = 5'd1;
  localparam logic [4:0] F_NEXT_NODE   = 5'd2;
  localparam logic [4:0] F_CPU_OP      = 5'd3;
  localparam logic [4:0] F_START_ADDR  = 5'd4;
  localparam logic [4:0] F_LEN         = 5'd5;
  localparam logic [4:0] F_INPUT_NODE  = 5'd6;
  localparam logic [4:0] F_OFFSET      = 5'd7;
  localparam logic [4:0] F_SRAM_OFFSET = 5'd13;
  localparam logic [4:0] F_DMEM        = 5'd14;
  localparam logic [4:0] F_DO_ADD      = 5'd15;
  localparam logic [4:0] F_OUTPUT_NODE = 5'd16;
  localparam logic [4:0] F_SMEM        = 5'd17;
  localparam logic [4:0] F_AXIS        = 5'd18;
  localparam logic [4:0] F_NUM_INPUTS  = 5'd19;
  localparam logic [4:0] F_CONCAT_IN   = 5'd20;
  localparam logic [4:0] F_SHIFT_EN    = 5'd21;
  localparam logic [4:0] F_LUT_ADDR    = 5'd22;
  localparam logic [4:0] F_DATA_ADDR   = 5'd23;
  localparam logic [4:0] F_FORMAT      = 5'd24;
  localparam logic [4:0] F_CHANNEL     = 5'd27;
  localparam logic [4:0] F_CHUNK_NUM   = 5'd28;
  localparam logic [4:0] F_CHUNK_START = 5'd29;
  // Marks the end of a node; never leaves the block
  localparam logic [4:0] F_DONE        = 5'd31;

  // Node kinds
  localparam logic [1:0] KIND_CPU  = 2'd0;
  localparam logic [1:0] KIND_NPU  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // CPU op subtypes
  localparam logic [3:0] OP_CDMA    = 4'd0;
  localparam logic [3:0] OP_WDMA    = 4'd1;
  localparam logic [3:0] OP_DIDMA   = 4'd2;
  localparam logic [3:0] OP_DODMA   = 4'd3;
  localparam logic [3:0] OP_CONCAT  = 4'd4;
  localparam logic [3:0] OP_PDMA    = 4'd5;
  localparam logic [3:0] OP_SHIFT   = 4'd6;
  localparam logic [3:0] OP_LUT     = 4'd7;
  localparam logic [3:0] OP_L2N     = 4'd8;
  localparam logic [3:0] OP_RESHAPE = 4'd9;
  localparam logic [3:0] OP_SOFTMAX = 4'd10;
  localparam logic [31:0] NUM_OPS   = 32'd11;

  localparam logic [31:0] CHUNKED_FMT = 32'd3;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BAD_OP   = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef struct packed {
    logic [31:0] owner_node;
    logic [1:0]  node_kind;
    logic [3:0]  cpu_op;
    logic [4:0]  field_code;
    logic [31:0] word_value;
    logic [27:0] sram_quot;
    logic [4:0]  sram_rem;
    logic        node_done;
    logic [1:0]  status;
  } ofdp_res_t;

  // First field after the op word
  function automatic logic [4:0] cpu_first(input logic [3:0] op);
    logic [4:0] f;
    case (op) inside
      OP_CDMA, OP_WDMA, OP_PDMA:                     f = F_START_ADDR;
      OP_DIDMA, OP_SHIFT, OP_L2N, OP_RESHAPE, OP_SOFTMAX: f = F_INPUT_NODE;
      OP_DODMA:                                      f = F_OUTPUT_NODE;
      OP_CONCAT:                                     f = F_AXIS;
      OP_LUT:                                        f = F_LUT_ADDR;
      default:                                       f = F_DONE;
    endcase
    return f;
  endfunction

  // Field that follows the given one in an op's list
  function automatic logic [4:0] cpu_next(input logic [3:0] op, input logic [4:0] fld);
    logic [4:0] f;
    f = F_DONE;
    case (op) inside
      OP_CDMA, OP_WDMA, OP_PDMA: begin
        if (fld == F_START_ADDR) f = F_LEN;
      end
      OP_DIDMA: begin
        if (fld >= F_INPUT_NODE && fld < F_DO_ADD) f = fld + 5'd1;
      end
      OP_DODMA: begin
        if (fld == F_OUTPUT_NODE) f = F_OFFSET;
        else if (fld >= F_OFFSET && fld < F_SRAM_OFFSET) f = fld + 5'd1;
        else if (fld == F_SRAM_OFFSET) f = F_SMEM;
      end
      OP_CONCAT: begin
        if (fld == F_AXIS) f = F_NUM_INPUTS;
        else if (fld == F_NUM_INPUTS) f = F_CONCAT_IN;
        else if (fld == F_CONCAT_IN) f = F_OUTPUT_NODE;
      end
      OP_SHIFT: begin
        if (fld == F_INPUT_NODE) f = F_OUTPUT_NODE;
        else if (fld == F_OUTPUT_NODE) f = F_SHIFT_EN;
        else if (fld == F_SHIFT_EN) f = F_START_ADDR;
        else if (fld == F_START_ADDR) f = F_LEN;
      end
      OP_L2N: begin
        if (fld == F_INPUT_NODE) f = F_OUTPUT_NODE;
        else if (fld == F_OUTPUT_NODE) f = F_START_ADDR;
      end
      OP_RESHAPE, OP_SOFTMAX: begin
        if (fld == F_INPUT_NODE) f = F_OUTPUT_NODE;
      end
      default: f = F_DONE;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

[hdl/ofdp_core.sv]
`default_nettype none

module ofdp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_accept,
  input  logic [7:0]         in_byte,
  input  logic               in_end,
  output logic               res_valid,
  output ofdp_pkg::ofdp_res_t res
);
  import ofdp_pkg::*;

  logic [1:0]  byte_phase,     byte_phase_next;
  logic [23:0] word_partial,   word_partial_next;
  logic [4:0]  next_field,     next_field_next;
  logic [1:0]  current_kind,   current_kind_next;
  logic [3:0]  current_op,     current_op_next;
  logic [31:0] current_node,   current_node_next;
  logic [31:0] list_left,      list_left_next;
  logic        chunked_format, chunked_format_next;
  logic        halted,         halted_next;

  logic [31:0] w;
  logic [31:0] cnt;
  logic        rnd;
  logic [4:0]  nxt;
  logic [1:0]  st;
  logic [1:0]  kind_v;
  logic [3:0]  op_v;
  logic [31:0] node_v;
  logic [31:0] left_v;
  logic        chunk_v;

  assign w   = {word_partial, in_byte};
  assign cnt = (!w[31] && w != 32'd0) ? w : 32'd0;
  // Truncating divide by 16 rounds negatives with a remainder up by one
  assign rnd = w[31] && (w[3:0] != 4'd0);

  // Field decode for a completed word
  always_comb begin
    nxt     = F_DONE;
    st      = ST_OK;
    kind_v  = current_kind;
    op_v    = current_op;
    node_v  = current_node;
    left_v  = list_left;
    chunk_v = chunked_format;
    case (next_field)
      F_NODE_INDEX: begin
        node_v = w;
        kind_v = KIND_CPU;
        op_v   = OP_CDMA;
        nxt    = F_NODE_TYPE;
      end
      F_NODE_TYPE: begin
        if (w[31:2] == 30'd0 && w[1:0] != 2'd3) begin
          kind_v = w[1:0];
          nxt    = (w[1:0] == KIND_DATA) ? F_DATA_ADDR : F_NEXT_NODE;
        end else begin
          st = ST_BAD_TYPE;
        end
      end
      F_NEXT_NODE: begin
        nxt = (current_kind == KIND_CPU) ? F_CPU_OP : F_DONE;
      end
      F_CPU_OP: begin
        if (w < NUM_OPS) begin
          op_v = w[3:0];
          nxt  = cpu_first(w[3:0]);
        end else begin
          st = ST_BAD_OP;
        end
      end
      default: begin
        if (current_kind == KIND_DATA) begin
          if (next_field == F_FORMAT) begin
            chunk_v = (w == CHUNKED_FMT);
            nxt     = next_field + 5'd1;
          end else if (next_field == F_CHANNEL) begin
            nxt = chunked_format ? F_CHUNK_NUM : F_DONE;
          end else if (next_field == F_CHUNK_NUM) begin
            left_v = cnt;
            nxt    = (cnt != 32'd0) ? F_CHUNK_START : F_DONE;
          end else if (next_field == F_CHUNK_START) begin
            if (list_left != 32'd0) left_v = list_left - 32'd1;
            nxt = (left_v != 32'd0) ? F_CHUNK_START : F_DONE;
          end else if (next_field >= F_DATA_ADDR && next_field < F_CHANNEL) begin
            nxt = next_field + 5'd1;
          end
        end else if (next_field == F_NUM_INPUTS) begin
          left_v = cnt;
          nxt    = (cnt != 32'd0) ? F_CONCAT_IN : F_OUTPUT_NODE;
        end else if (next_field == F_CONCAT_IN) begin
          if (list_left != 32'd0) left_v = list_left - 32'd1;
          nxt = (left_v != 32'd0) ? F_CONCAT_IN : F_OUTPUT_NODE;
        end else begin
          nxt = cpu_next(current_op, next_field);
        end
      end
    endcase
  end

  // State update and result
  always_comb begin
    byte_phase_next     = byte_phase;
    word_partial_next   = word_partial;
    next_field_next     = next_field;
    current_kind_next   = current_kind;
    current_op_next     = current_op;
    current_node_next   = current_node;
    list_left_next      = list_left;
    chunked_format_next = chunked_format;
    halted_next         = halted;
    res_valid           = 1'b0;
    res                 = '0;
    if (in_accept && !halted) begin
      if (byte_phase != 2'd3) begin
        // Hold partial bytes; a flow end here cuts the word short
        word_partial_next = {word_partial[15:0], in_byte};
        byte_phase_next   = byte_phase + 2'd1;
        if (in_end) begin
          halted_next    = 1'b1;
          res_valid      = 1'b1;
          res.owner_node = current_node;
          res.node_kind  = current_kind;
          res.cpu_op     = current_op;
          res.field_code = next_field;
          res.status     = ST_TRUNC;
        end
      end else begin
        byte_phase_next   = 2'd0;
        word_partial_next = 24'd0;
        res_valid         = 1'b1;
        res.owner_node    = node_v;
        res.field_code    = next_field;
        res.word_value    = w;
        if (next_field == F_SRAM_OFFSET) begin
          res.sram_quot = w[31:4] + {27'd0, rnd};
          res.sram_rem  = {rnd, w[3:0]};
        end
        if (st != ST_OK) begin
          halted_next = 1'b1;
          res.status  = st;
        end else if (nxt == F_DONE) begin
          next_field_next     = F_NODE_INDEX;
          current_kind_next   = KIND_CPU;
          current_op_next     = OP_CDMA;
          current_node_next   = node_v;
          list_left_next      = 32'd0;
          chunked_format_next = 1'b0;
          res.node_kind       = kind_v;
          res.cpu_op          = op_v;
          res.node_done       = 1'b1;
        end else begin
          next_field_next     = nxt;
          current_kind_next   = kind_v;
          current_op_next     = op_v;
          current_node_next   = node_v;
          list_left_next      = left_v;
          chunked_format_next = chunk_v;
          res.node_kind       = kind_v;
          res.cpu_op          = op_v;
          if (in_end) begin
            halted_next = 1'b1;
            res.status  = ST_TRUNC;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= 2'd0;
      word_partial   <= 24'd0;
      next_field     <= F_NODE_INDEX;
      current_kind   <= KIND_CPU;
      current_op     <= OP_CDMA;
      current_node   <= 32'd0;
      list_left      <= 32'd0;
      chunked_format <= 1'b0;
      halted         <= 1'b0;
    end else begin
      byte_phase     <= byte_phase_next;
      word_partial   <= word_partial_next;
      next_field     <= next_field_next;
      current_kind   <= current_kind_next;
      current_op     <= current_op_next;
      current_node   <= current_node_next;
      list_left      <= list_left_next;
      chunked_format <= chunked_format_next;
      halted         <= halted_next;
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("parser left the halted state without reset");

  a_no_result_when_halted: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !halted)
    else $error("result produced while halted");

  a_partial_silent: assert property (@(posedge clk) disable iff (rst)
    (in_accept && byte_phase != 2'd3 && !in_end) |-> !res_valid)
    else $error("result produced for an incomplete word");

  a_clean_end_restart: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.node_done) |=> (next_field == F_NODE_INDEX && !halted))
    else $error("parser did not restart at a node index after a node ended");
`endif

endmodule

`default_nettype wire

[hdl/ofdp_out_reg.sv]
`default_nettype none

module ofdp_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                res_valid,
  input  ofdp_pkg::ofdp_res_t res,
  input  logic                out_ready,
  output logic                out_valid,
  output ofdp_pkg::ofdp_res_t out_res,
  output logic                in_ready
);
  import ofdp_pkg::*;

  // Take a new word whenever the held result is empty or leaving this cycle
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && res_valid) begin
      out_res <= res;
    end
  end

`ifndef SYNTHESIS
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_res)))
    else $error("stalled result changed or dropped");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked while the result register is empty");

  a_load_on_result: assert property (@(posedge clk) disable iff (rst)
    (in_ready && res_valid) |=> out_valid)
    else $error("result lost on load");
`endif

endmodule

`default_nettype wire

[hdl/op_flow_descriptor_parser.sv]
// A result word appears on m_* in the cycle after the byte that completes it.
// Throughput: one byte accepted per cycle; a stall on m_tready holds s_tready low
// only while the single result register is full and not being taken.
// Reset (rst, synchronous, active high) clears the byte phase, node bookkeeping,
// the halt flag and the result valid; the parser then expects a node index.
`default_nettype none

module op_flow_descriptor_parser (
  input  logic         clk,
  input  logic         rst,
  // byte stream in
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] stream_byte
  input  logic         s_tlast,   // stream_end
  // tagged word stream out
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] owner_node, [33:32] node_kind, [37:34] cpu_op, [42:38] field_code,
  // [74:43] word_value, [102:75] sram_quot, [107:103] sram_rem, [111:108] zero
  output logic [111:0] m_tdata,
  output logic         m_tlast,   // node_done
  output logic [1:0]   m_tuser    // status
);
  import ofdp_pkg::*;

  logic      accept;
  logic      res_valid;
  ofdp_res_t res;
  ofdp_res_t out_res;

  // A byte is taken when the result register can take whatever it produces
  assign accept = s_tvalid && s_tready;

  // Parser state and field decode: assemble words, tag them, track the node layout
  ofdp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .in_accept (accept),
    .in_byte   (s_tdata),
    .in_end    (s_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: parts the input side from a stalled output
  ofdp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_res   (out_res),
    .in_ready  (s_tready)
  );

  // Pack the result fields, lowest field in the lowest bits
  assign m_tdata = {4'd0,
                    out_res.sram_rem,
                    out_res.sram_quot,
                    out_res.word_value,
                    out_res.field_code,
                    out_res.cpu_op,
                    out_res.node_kind,
                    out_res.owner_node};
  assign m_tlast = out_res.node_done;
  assign m_tuser = out_res.status;

endmodule

`default_nettype wire
